>>> rtl/core/sva_pkg.sv
// Package: shared types, constants and codes for the voice allocator.
package sva_pkg;
  localparam int unsigned VOICES = 16;
  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW = $clog2(VOICES + 1);

  localparam logic [2:0] FN_NOTE_ON  = 3'd0;
  localparam logic [2:0] FN_NOTE_OFF = 3'd1;
  localparam logic [2:0] FN_SUSTAIN  = 3'd2;
  localparam logic [2:0] FN_SOST     = 3'd3;
  localparam logic [2:0] FN_ALL_OFF  = 3'd4;
  localparam logic [2:0] FN_PANIC    = 3'd5;
  localparam logic [2:0] FN_ENERGY   = 3'd6;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DAMP  = 2'd1;
  localparam logic [1:0] ACT_OFF   = 2'd2;
  localparam logic [1:0] ACT_RESET = 2'd3;

  localparam logic [1:0] CFG_REL   = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [1:0] CFG_FLOOR = 2'd2;

  localparam logic [24:0] ENERGY_ONE = 25'd16777216;

  // voice record that travels down the ring
  typedef struct packed {
    logic        active;
    logic        down;
    logic        sus;
    logic        latch;
    logic [6:0]  key;
    logic [24:0] energy;
    logic [31:0] stamp;
  } voice_t;

  // per-event command the sequencer applies to the voice at the ring head
  typedef struct packed {
    logic [2:0]  func;
    logic [6:0]  key;
    logic        sdown;
    logic        hold;       // pedal holds releases (current level)
    logic        lift;       // pedal fell below release threshold
    logic        st_held;    // start sustained
    logic [24:0] energy;
    logic        busy;
    logic [24:0] floor_v;
    logic [31:0] stamp;      // new stamp for a start
  } ev_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_PICK, ST_WRITE, ST_DONE
  } state_t;
endpackage

>>> rtl/core/sva_cell.sv
// One ring cell: holds one voice record, passes it to its neighbor on shift.
module sva_cell
  import sva_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift,
  input  voice_t d_in,
  output voice_t q
);
  voice_t q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= d_in;
    end
  end
  assign q = q_r;
endmodule

>>> rtl/core/sva_ring.sv
// Ring of voice cells; head voice leaves through an update unit each shift.
module sva_ring
  import sva_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   shift,
  input  voice_t head_new,
  output voice_t head
);
  voice_t q [VOICES];
  for (genvar i = 0; i < VOICES; i++) begin : g_cell
    voice_t d;
    if (i == VOICES - 1) begin : g_tail
      assign d = head_new;
    end else begin : g_mid
      assign d = q[i+1];
    end
    sva_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d_in(d), .q(q[i]));
  end
  assign head = q[0];
endmodule

>>> rtl/core/synth_voice_allocator.sv
// Top level: event sequencer, voice ring and one-deep result register.
// A note on passes through a pick rotation, a write rotation and done before the start
//   word; other events go through one scan rotation and done to the last word.
// The next event is accepted only once the sequencer is back in idle; a scan pass and
//   done stall while a result word waits.
// Reset (rst_n low, synchronous): voices cleared, thresholds 115/128/335.
module synth_voice_allocator
  import sva_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [6:0]  in_key,
  input  logic [6:0]  in_strike,
  input  logic [7:0]  in_pedal_value,
  input  logic        in_sost_down,
  input  logic [3:0]  in_voice_sel,
  input  logic [24:0] in_energy_in,
  input  logic        in_hammer_busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_action,
  output logic [3:0]  out_voice_out,
  output logic [6:0]  out_key_out,
  output logic [6:0]  out_strike_out,
  output logic        out_start_held,
  output logic        out_last
);
  // config registers
  logic [7:0]  rel_th_r, st_th_r;
  logic [24:0] floor_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_th_r <= 8'd115;
      st_th_r  <= 8'd128;
      floor_r  <= 25'd335;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REL:   rel_th_r <= cfg_data[7:0];
        CFG_START: st_th_r  <= cfg_data[7:0];
        CFG_FLOOR: floor_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  state_t      st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;       // cells rotated in this pass
  logic [1:0]  cls_r, cls_nxt;         // pick class: 0 same key,1 free,2 released,3 oldest
  logic [VW-1:0] best_r, best_nxt;
  logic [31:0] bval_r, bval_nxt;       // best energy or age
  logic        bok_r, bok_nxt;
  logic [31:0] stamp_cnt_r, stamp_cnt_nxt;
  logic [7:0]  pedal_r, pedal_nxt;
  ev_t         ev_r, ev_nxt;
  logic [6:0]  strike_r, strike_nxt;
  logic [3:0]  sel_r, sel_nxt;
  logic        sel_ok_r, sel_ok_nxt;
  // pending result (held until the next one or pass end decides last)
  logic        pv_r, pv_nxt;
  logic [1:0]  pa_r, pa_nxt;
  logic [3:0]  pvo_r, pvo_nxt;
  logic        ph_r, ph_nxt;
  // output register
  logic        ov_r, ov_nxt;
  logic [1:0]  oa_r, oa_nxt;
  logic [3:0]  ovo_r, ovo_nxt;
  logic [6:0]  ok_r, ok_nxt, os_r, os_nxt;
  logic        oh_r, oh_nxt, ol_r, ol_nxt;

  logic   shift;
  voice_t head, head_new;
  sva_ring u_ring (.clk(clk), .rst_n(rst_n), .shift(shift), .head_new(head_new),
                   .head(head));

  logic [VW-1:0] idx;
  logic [31:0]   age;
  logic          emit;
  logic [1:0]    emit_act;
  logic          emit_held;
  logic          out_free;
  logic          hold_now;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; cls_nxt = cls_r; best_nxt = best_r;
    bval_nxt = bval_r; bok_nxt = bok_r; stamp_cnt_nxt = stamp_cnt_r;
    pedal_nxt = pedal_r; ev_nxt = ev_r; strike_nxt = strike_r; sel_nxt = sel_r;
    sel_ok_nxt = sel_ok_r;
    pv_nxt = pv_r; pa_nxt = pa_r; pvo_nxt = pvo_r; ph_nxt = ph_r;
    ov_nxt = ov_r; oa_nxt = oa_r; ovo_nxt = ovo_r; ok_nxt = ok_r; os_nxt = os_r;
    oh_nxt = oh_r; ol_nxt = ol_r;
    shift = 1'b0; head_new = head; emit = 1'b0; emit_act = ACT_DAMP; emit_held = 1'b0;
    in_ready = 1'b0;
    idx = cnt_r[VW-1:0];
    age = ev_r.stamp - 32'd1 - head.stamp;
    hold_now = (pedal_r >= rel_th_r);
    if (ov_r && out_ready) ov_nxt = 1'b0;
    out_free = !ov_r || out_ready;

    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ev_nxt.func = in_func; ev_nxt.key = in_key; ev_nxt.sdown = in_sost_down;
          ev_nxt.energy = in_energy_in; ev_nxt.busy = in_hammer_busy;
          ev_nxt.floor_v = floor_r;
          ev_nxt.hold = hold_now;
          ev_nxt.lift = 1'b0;
          ev_nxt.st_held = (pedal_r >= st_th_r);
          ev_nxt.stamp = stamp_cnt_r + 32'd1;
          strike_nxt = in_strike; sel_nxt = in_voice_sel;
          sel_ok_nxt = ({1'b0, in_voice_sel} < 5'(VOICES));
          cnt_nxt = '0; cls_nxt = 2'd3; best_nxt = '0; bval_nxt = '0; bok_nxt = 1'b0;
          pv_nxt = 1'b0;
          if (in_func == FN_SUSTAIN) begin
            pedal_nxt = in_pedal_value;
            ev_nxt.lift = hold_now && (in_pedal_value < rel_th_r);
            ev_nxt.hold = (in_pedal_value >= rel_th_r);
          end
          if (in_func == FN_NOTE_ON && in_strike != 7'd0) begin
            st_nxt = ST_PICK;
          end else if (in_func == FN_NOTE_ON) begin
            ev_nxt.func = FN_NOTE_OFF; st_nxt = ST_SCAN;
          end else if (in_func == FN_PANIC) begin
            ev_nxt.func = FN_PANIC; st_nxt = ST_SCAN;
            pv_nxt = 1'b1; pa_nxt = ACT_RESET; pvo_nxt = '0; ph_nxt = 1'b0;
          end else begin
            st_nxt = ST_SCAN;
          end
        end
      end
      ST_PICK: begin
        // one rotation, tracking best candidate in priority class order
        shift = 1'b1;
        if (head.active && head.key == ev_r.key) begin
          if (cls_r != 2'd0) begin cls_nxt = 2'd0; best_nxt = idx; end
        end else if (!head.active) begin
          if (cls_r > 2'd1) begin cls_nxt = 2'd1; best_nxt = idx; end
        end else if (!head.down) begin
          if (cls_r == 2'd3) begin
            cls_nxt = 2'd2; best_nxt = idx; bval_nxt = {7'd0, head.energy};
          end else if (cls_r == 2'd2 && {7'd0, head.energy} < bval_r) begin
            best_nxt = idx; bval_nxt = {7'd0, head.energy};
          end
        end else if (cls_r == 2'd3) begin
          if (!bok_r || age > bval_r) begin
            best_nxt = idx; bval_nxt = age; bok_nxt = 1'b1;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(VOICES - 1)) begin cnt_nxt = '0; st_nxt = ST_WRITE; end
      end
      ST_WRITE: begin
        shift = 1'b1;
        if (idx == best_r) begin
          head_new.key = ev_r.key; head_new.down = 1'b1; head_new.latch = 1'b0;
          head_new.active = 1'b1; head_new.energy = ENERGY_ONE;
          head_new.stamp = ev_r.stamp; head_new.sus = ev_r.st_held;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(VOICES - 1)) begin
          stamp_cnt_nxt = ev_r.stamp;
          pv_nxt = 1'b1; pa_nxt = ACT_START; pvo_nxt = 4'(best_r); ph_nxt = ev_r.st_held;
          st_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        // stall whole pass while a pending result can't move forward
        if (!(pv_r && !out_free)) begin
          shift = 1'b1;
          unique case (ev_r.func)
            FN_NOTE_OFF, FN_ALL_OFF: begin
              if (head.active && head.down &&
                  (ev_r.func == FN_ALL_OFF || head.key == ev_r.key)) begin
                head_new.down = 1'b0;
                if (ev_r.hold || head.latch) head_new.sus = 1'b1;
                else begin head_new.sus = 1'b0; emit = 1'b1; end
              end
            end
            FN_SUSTAIN: begin
              if (ev_r.lift && head.active && !head.down && !head.latch) begin
                head_new.sus = 1'b0; emit = 1'b1;
              end
            end
            FN_SOST: begin
              if (ev_r.sdown) begin
                if (head.active && head.down) head_new.latch = 1'b1;
              end else if (head.latch) begin
                head_new.latch = 1'b0;
                if (!head.down && !ev_r.hold && head.active) begin
                  head_new.sus = 1'b0; emit = 1'b1;
                end
              end
            end
            FN_PANIC: begin
              head_new.active = 1'b0; head_new.down = 1'b0; head_new.sus = 1'b0;
              head_new.latch = 1'b0; head_new.energy = '0;
            end
            FN_ENERGY: begin
              if (sel_ok_r && idx == sel_r[VW-1:0] && head.active) begin
                head_new.energy = ev_r.energy;
                if (!head.down && !ev_r.busy && ev_r.energy < ev_r.floor_v) begin
                  head_new.active = 1'b0; head_new.sus = 1'b0; head_new.latch = 1'b0;
                  emit = 1'b1; emit_act = ACT_OFF;
                end
              end
            end
            default: ;
          endcase
          if (emit) begin
            if (pv_r) begin
              ov_nxt = 1'b1; oa_nxt = pa_r; ovo_nxt = pvo_r; ok_nxt = '0; os_nxt = '0;
              oh_nxt = 1'b0; ol_nxt = 1'b0;
            end
            pv_nxt = 1'b1; pa_nxt = emit_act; pvo_nxt = 4'(idx); ph_nxt = emit_held;
          end
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CW'(VOICES - 1)) begin cnt_nxt = '0; st_nxt = ST_DONE; end
        end
      end
      ST_DONE: begin
        if (!pv_r) st_nxt = ST_IDLE;
        else if (out_free) begin
          ov_nxt = 1'b1; oa_nxt = pa_r; ovo_nxt = pvo_r; ol_nxt = 1'b1;
          oh_nxt = ph_r;
          ok_nxt = (pa_r == ACT_START) ? ev_r.key : 7'd0;
          os_nxt = (pa_r == ACT_START) ? strike_r : 7'd0;
          pv_nxt = 1'b0; st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; stamp_cnt_r <= '0; pedal_r <= '0;
      pv_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; stamp_cnt_r <= stamp_cnt_nxt;
      pedal_r <= pedal_nxt; pv_r <= pv_nxt; ov_r <= ov_nxt;
    end
  end
  always_ff @(posedge clk) begin
    cls_r <= cls_nxt; best_r <= best_nxt; bval_r <= bval_nxt; bok_r <= bok_nxt;
    ev_r <= ev_nxt; strike_r <= strike_nxt; sel_r <= sel_nxt; sel_ok_r <= sel_ok_nxt;
    pa_r <= pa_nxt; pvo_r <= pvo_nxt; ph_r <= ph_nxt;
    oa_r <= oa_nxt; ovo_r <= ovo_nxt; ok_r <= ok_nxt; os_r <= os_nxt;
    oh_r <= oh_nxt; ol_r <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_action = oa_r;
  assign out_voice_out = ovo_r;
  assign out_key_out = ok_r;
  assign out_strike_out = os_r;
  assign out_start_held = oh_r;
  assign out_last = ol_r;
endmodule

>>> rtl/core/sva_checker.sv
// Port checker for the voice allocator, bound to the top level.
module sva_checker
  import sva_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_action,
  input logic [6:0] out_key_out,
  input logic       out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action))
    else $error("result word dropped while stalled");
  a_start_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_START |-> out_last)
    else $error("start not marked last");
  a_reset_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_RESET |-> out_last)
    else $error("reset all not marked last");
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_START |-> out_key_out == 7'd0)
    else $error("key on non-start word");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted word while busy");
endmodule

bind synth_voice_allocator sva_checker u_sva_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_action(out_action),
  .out_key_out(out_key_out), .out_last(out_last)
);

>>> verif/tb.sv
// Testbench for synth_voice_allocator: predicts the command stream of each event and checks it.
module tb;
  import sva_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic [6:0]  in_key;
  logic [6:0]  in_strike;
  logic [7:0]  in_pedal_value;
  logic        in_sost_down;
  logic [3:0]  in_voice_sel;
  logic [24:0] in_energy_in;
  logic        in_hammer_busy;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [24:0] cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_action;
  logic [3:0]  out_voice_out;
  logic [6:0]  out_key_out;
  logic [6:0]  out_strike_out;
  logic        out_start_held;
  logic        out_last;

  synth_voice_allocator dut (.*);

  // one expected command word
  typedef struct packed {
    logic [1:0] action;
    logic [3:0] voice;
    logic [6:0] key;
    logic [6:0] strike;
    logic       held;
    logic       last;
  } cmd_t;

  cmd_t cmd_queue[$];

  // allocator state mirrored by the predictor
  logic [7:0]  rel_thr;
  logic [7:0]  sus_thr;
  logic [24:0] e_floor;
  logic        v_act   [VOICES];
  logic        v_down  [VOICES];
  logic        v_sus   [VOICES];
  logic        v_latch [VOICES];
  logic [6:0]  v_key   [VOICES];
  logic [24:0] v_energy[VOICES];
  logic [31:0] v_stamp [VOICES];
  logic [31:0] stamp_ctr;
  logic [7:0]  pedal_lvl;

  int  errors = 0;
  int  words_in;
  int  words_out = 0;
  int  idle_cycles = 0;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  recv_hold;
  int  pend_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_cmd(logic [1:0] a, int v, logic [6:0] k, logic [6:0] s,
                                   logic h);
    cmd_t c;
    c.action = a;
    c.voice  = v[3:0];
    c.key    = k;
    c.strike = s;
    c.held   = h;
    c.last   = 1'b0;
    cmd_queue.push_back(c);
    pend_cnt++;
  endfunction

  function automatic void model_clear();
    rel_thr   = 8'd115;
    sus_thr   = 8'd128;
    e_floor   = 25'd335;
    stamp_ctr = '0;
    pedal_lvl = '0;
    for (int v = 0; v < VOICES; v++) begin
      v_act[v] = 0; v_down[v] = 0; v_sus[v] = 0; v_latch[v] = 0;
      v_key[v] = '0; v_energy[v] = '0; v_stamp[v] = '0;
    end
  endfunction

  function automatic bit holds();
    return pedal_lvl >= rel_thr;
  endfunction

  function automatic void damp(int v);
    if (!v_act[v] || v_down[v]) return;
    v_sus[v] = 0;
    push_cmd(ACT_DAMP, v, '0, '0, 1'b0);
  endfunction

  function automatic void release_v(int v);
    v_down[v] = 0;
    if (holds() || v_latch[v]) v_sus[v] = 1;
    else damp(v);
  endfunction

  function automatic int choose_voice(logic [6:0] k);
    int best;
    logic [24:0] low;
    logic [31:0] age;
    logic [31:0] oldest;
    best = -1;
    low = '0;
    for (int v = 0; v < VOICES; v++) if (v_act[v] && v_key[v] == k) return v;
    for (int v = 0; v < VOICES; v++) if (!v_act[v]) return v;
    for (int v = 0; v < VOICES; v++) begin
      if (v_down[v]) continue;
      if (best < 0 || v_energy[v] < low) begin
        low = v_energy[v];
        best = v;
      end
    end
    if (best >= 0) return best;
    best = 0;
    oldest = stamp_ctr - v_stamp[0];
    for (int v = 1; v < VOICES; v++) begin
      age = stamp_ctr - v_stamp[v];
      if (age > oldest) begin
        oldest = age;
        best = v;
      end
    end
    return best;
  endfunction

  // predicts the commands caused by one event and queues them
  function automatic void predict_event(logic [2:0] fn, logic [6:0] k, logic [6:0] s,
                                        logic [7:0] pv, logic sd, logic [3:0] sel,
                                        logic [24:0] e, logic busy);
    int  v;
    bit  was;
    pend_cnt = 0;
    case (fn)
      FN_NOTE_ON, FN_NOTE_OFF: begin
        if (fn == FN_NOTE_OFF || s == 0) begin
          for (v = 0; v < VOICES; v++)
            if (v_act[v] && v_down[v] && v_key[v] == k) release_v(v);
        end else begin
          v = choose_voice(k);
          v_key[v] = k; v_down[v] = 1; v_latch[v] = 0; v_act[v] = 1;
          v_energy[v] = ENERGY_ONE;
          stamp_ctr = stamp_ctr + 1;
          v_stamp[v] = stamp_ctr;
          v_sus[v] = pedal_lvl >= sus_thr;
          push_cmd(ACT_START, v, k, s, v_sus[v]);
        end
      end
      FN_SUSTAIN: begin
        was = holds();
        pedal_lvl = pv;
        if (was && !holds())
          for (v = 0; v < VOICES; v++)
            if (v_act[v] && !v_down[v] && !v_latch[v]) damp(v);
      end
      FN_SOST: begin
        for (v = 0; v < VOICES; v++) begin
          if (sd) begin
            if (v_act[v] && v_down[v]) v_latch[v] = 1;
          end else if (v_latch[v]) begin
            v_latch[v] = 0;
            if (!v_down[v] && !holds()) damp(v);
          end
        end
      end
      FN_ALL_OFF: begin
        for (v = 0; v < VOICES; v++) if (v_act[v] && v_down[v]) release_v(v);
      end
      FN_PANIC: begin
        for (v = 0; v < VOICES; v++) begin
          v_act[v] = 0; v_down[v] = 0; v_sus[v] = 0; v_latch[v] = 0; v_energy[v] = '0;
        end
        push_cmd(ACT_RESET, 0, '0, '0, 1'b0);
      end
      FN_ENERGY: begin
        if (sel < VOICES && v_act[sel]) begin
          v_energy[sel] = e;
          if (!v_down[sel] && !busy && e < e_floor) begin
            v_act[sel] = 0; v_sus[sel] = 0; v_latch[sel] = 0;
            push_cmd(ACT_OFF, sel, '0, '0, 1'b0);
          end
        end
      end
      default: ;
    endcase
    if (pend_cnt > 0) cmd_queue[cmd_queue.size() - 1].last = 1'b1;
  endfunction

  // sends one event; prediction happens at acceptance
  task automatic send_event(logic [2:0] fn, logic [6:0] k, logic [6:0] s, logic [7:0] pv,
                            logic sd, logic [3:0] sel, logic [24:0] e, logic busy);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid       <= 1'b1;
    in_func        <= fn;
    in_key         <= k;
    in_strike      <= s;
    in_pedal_value <= pv;
    in_sost_down   <= sd;
    in_voice_sel   <= sel;
    in_energy_in   <= e;
    in_hammer_busy <= busy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_event(fn, k, s, pv, sd, sel, e, busy);
    words_in++;
    in_valid <= 1'b0;
    // the block stays busy after acceptance until the pass for this event ends
    @(posedge clk);
  endtask

  task automatic note_on(logic [6:0] k, logic [6:0] s);
    send_event(FN_NOTE_ON, k, s, 8'($urandom), 1'($urandom), 4'($urandom), 25'($urandom),
               1'($urandom));
  endtask

  task automatic event_of(logic [2:0] fn, logic [6:0] k, logic [7:0] pv, logic sd,
                          logic [3:0] sel, logic [24:0] e, logic busy);
    send_event(fn, k, 7'($urandom), pv, sd, sel, e, busy);
  endtask

  // waits until every command is in, then lets the last pass finish
  task automatic drain();
    while (cmd_queue.size() != 0) @(posedge clk);
    repeat (2 * VOICES + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [24:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_REL:   rel_thr = val[7:0];
      CFG_START: sus_thr = val[7:0];
      CFG_FLOOR: e_floor = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // checker: each accepted command against the oldest prediction
  always @(posedge clk) begin
    cmd_t got;
    cmd_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      words_out++;
      got = {out_action, out_voice_out, out_key_out, out_strike_out, out_start_held, out_last};
      if (cmd_queue.size() == 0) begin
        $display("%0t: unexpected command act=%0d voice=%0d", $time, out_action,
                 out_voice_out);
        errors++;
      end else begin
        exp_c = cmd_queue.pop_front();
        if (got !== exp_c) begin
          $display("%0t: mismatch exp act=%0d v=%0d k=%0d s=%0d h=%0d l=%0d",
                   $time, exp_c.action, exp_c.voice, exp_c.key, exp_c.strike,
                   exp_c.held, exp_c.last);
          $display("%0t:          got act=%0d v=%0d k=%0d s=%0d h=%0d l=%0d",
                   $time, got.action, got.voice, got.key, got.strike, got.held,
                   got.last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Watchdog: no progress, %0d commands pending", cmd_queue.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // fill the voices, then note-on steals; covers every pick rule
  task automatic test_allocation();
    for (int i = 0; i < VOICES; i++) note_on(7'(i * 8 + 3), 7'(i + 1));
    note_on(7'd3, 7'd127);           // same key retrigger
    event_of(FN_NOTE_OFF, 7'd11, 0, 0, 0, 0, 0);
    event_of(FN_NOTE_OFF, 7'd19, 0, 0, 0, 0, 0);
    event_of(FN_ENERGY, 0, 0, 0, 4'd2, 25'd1000, 1'b1);
    note_on(7'd127, 7'd1);           // lowest-energy released voice
    note_on(7'd0, 7'd64);            // released voice at full energy
    note_on(7'd100, 7'd5);           // all keys down: oldest voice
    send_event(FN_NOTE_ON, 7'd35, 7'd0, 0, 0, 0, 0, 0);   // zero velocity
    event_of(FN_ENERGY, 0, 0, 0, 4'd4, 25'd0, 1'b0);      // voice ends
    event_of(FN_ENERGY, 0, 0, 0, 4'd4, 25'h1FFFFFF, 1'b1); // now inactive: ignored
    event_of(3'd7, 7'h7F, 8'hFF, 1, 4'hF, 25'h1FFFFFF, 1); // unused code
    event_of(FN_PANIC, 0, 0, 0, 0, 0, 0);
  endtask

  // pedals: hold, lift, sostenuto latch and release, all off
  task automatic test_pedals();
    event_of(FN_SUSTAIN, 0, 8'd255, 0, 0, 0, 0);
    note_on(7'd60, 7'd90);
    note_on(7'd62, 7'd90);
    event_of(FN_NOTE_OFF, 7'd60, 0, 0, 0, 0, 0);
    event_of(FN_SUSTAIN, 0, 8'd0, 0, 0, 0, 0);            // lift damps key 60
    note_on(7'd64, 7'd70);
    event_of(FN_SOST, 0, 0, 1'b1, 0, 0, 0);
    event_of(FN_ALL_OFF, 0, 0, 0, 0, 0, 0);
    event_of(FN_SOST, 0, 0, 1'b0, 0, 0, 0);               // latched ones damped
    event_of(FN_PANIC, 0, 0, 0, 0, 0, 0);
  endtask

  function automatic logic [6:0] pick_key();
    return ($urandom_range(3) == 0) ? 7'($urandom) : 7'(40 + $urandom_range(23));
  endfunction

  // random play: mostly notes, with pedals and energy reports mixed in
  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 40) note_on(pick_key(), ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom));
      else if (r < 60) event_of(FN_NOTE_OFF, pick_key(), 0, 0, 0, 0, 0);
      else if (r < 70) event_of(FN_SUSTAIN, 0, 8'($urandom), 0, 0, 0, 0);
      else if (r < 76) event_of(FN_SOST, 0, 0, 1'($urandom), 0, 0, 0);
      else if (r < 79) event_of(FN_ALL_OFF, 0, 0, 0, 0, 0, 0);
      else if (r < 81) event_of(FN_PANIC, 0, 0, 0, 0, 0, 0);
      else if (r < 98)
        event_of(FN_ENERGY, 0, 0, 0, 4'($urandom),
                 ($urandom_range(1)) ? 25'($urandom_range(700)) : 25'($urandom) & 25'h1FFFFFF,
                 $urandom_range(3) == 0);
      else send_event(3'd7, 7'($urandom), 7'($urandom), 8'($urandom), 1'($urandom),
                      4'($urandom), 25'($urandom), 1'($urandom));
    end
  endtask

  // long receiver hold-off while events keep coming
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1;
        repeat (400) @(posedge clk);
        recv_hold = 0;
      end
      for (int i = 0; i < 10; i++) note_on(7'(20 + i), 7'd33);
    join
    drain();
  endtask

  initial begin
    model_clear();
    words_in = 0;
    send_idle_pct = 0; recv_stall_pct = 0; recv_hold = 0;
    rst_n = 1'b0;
    in_valid = 0; in_func = '0; in_key = '0; in_strike = '0; in_pedal_value = '0;
    in_sost_down = 0; in_voice_sel = '0; in_energy_in = '0; in_hammer_busy = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_allocation();
    test_pedals();
    drain();

    // extremes of the registers, then back near defaults
    write_reg(CFG_REL, 25'd0);
    write_reg(CFG_START, 25'd255);
    write_reg(CFG_FLOOR, 25'd16777216);
    send_idle_pct = 66;
    test_random(20);
    drain();

    write_reg(CFG_REL, 25'd255);
    write_reg(CFG_START, 25'd0);
    write_reg(CFG_FLOOR, 25'd0);
    send_idle_pct = 0; recv_stall_pct = 66;
    test_random(20);
    drain();

    write_reg(CFG_REL, 25'd115);
    write_reg(CFG_START, 25'd128);
    write_reg(CFG_FLOOR, 25'd400);
    send_idle_pct = 30; recv_stall_pct = 30;
    test_random(30);
    drain();

    send_idle_pct = 0; recv_stall_pct = 0;
    test_backpressure();
    test_random(20);
    drain();

    $display("Ran %0d events through pick, steal, pedal, energy and panic paths", words_in);
    $display("with four register settings and idle mixes; %0d commands checked", words_out);
    if (errors == 0 && cmd_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Errors: %0d, commands missing: %0d", errors, cmd_queue.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
